@@ hw/rtl/bvt_pkg.sv @@
// ----------------------------------------------------------------------------
// bvt_pkg: shared types and constants of the bimodal valley threshold core
// Sizes of the bin store, product width, scan modes and controller states.
// ----------------------------------------------------------------------------
package bvt_pkg;

    localparam int BINS        = 256;
    localparam int ADDR_BITS   = $clog2(BINS);
    localparam int COUNT_BITS  = 24;
    localparam int IN_COUNT_W  = 24;
    localparam int LEVEL_W     = 8;
    localparam int PROD_BITS   = COUNT_BITS + ADDR_BITS;

    localparam logic [32:0] COUNT_LIMIT = (33'(1) << COUNT_BITS) - 33'(1);

    typedef enum logic [1:0] {
        SCAN_PEAK_ONE,
        SCAN_PEAK_TWO,
        SCAN_VALLEY
    } scan_mode_t;

    typedef enum logic [3:0] {
        ST_IDLE,
        ST_START_ONE,
        ST_RUN_ONE,
        ST_START_TWO,
        ST_RUN_TWO,
        ST_START_THREE,
        ST_RUN_THREE,
        ST_DONE,
        ST_HOLD
    } ctrl_state_t;

    typedef struct packed {
        logic       start;
        scan_mode_t mode;
    } scan_cmd_t;

    typedef struct packed {
        logic scan_done;
    } scan_status_t;

    // clamp an incoming count to the stored count width
    function automatic logic [COUNT_BITS-1:0] sat_count(input logic [IN_COUNT_W-1:0] c);
        logic [32:0] ext;
        ext = 33'(c);
        if (ext > COUNT_LIMIT) begin
            return COUNT_BITS'(COUNT_LIMIT);
        end
        return COUNT_BITS'(ext);
    endfunction

endpackage

@@ hw/rtl/bimodal_valley_threshold_core.sv @@
// ----------------------------------------------------------------------------
// bimodal_valley_threshold_core: two-peak valley threshold over a histogram
// Loads histogram bins and returns the valley threshold and both peaks.
// ----------------------------------------------------------------------------
// Input channel (s_): one beat per bin, s_bin_index and s_bin_count. A beat
// with s_last_bin set is stored like any other and then starts the search.
// Loading beats are taken one per cycle while the core is idle.
// Output channel (m_): one beat per search, carrying m_threshold_level,
// m_first_peak and m_second_peak.
// The search runs three scans over the bin store, each reading one bin per
// cycle through the store's single read port: highest bin, largest count
// times distance, then lowest bin between the peaks. The first two cover all
// 256 bins; the valley scan covers hi - lo bins (one when the peaks
// coincide).
// While the result waits on m_ready, loading beats of the next histogram
// are still taken; a last beat taken then holds the input side until the
// result has gone, and the new search starts after that.
// Reset (aresetn low, synchronous) clears the controller and the peak
// registers; the bin store holds no valid contents until written.
// ----------------------------------------------------------------------------
module bimodal_valley_threshold_core (
    input  logic                           aclk,
    input  logic                           aresetn,
    input  logic                           s_valid,
    output logic                           s_ready,
    input  logic [7:0]                     s_bin_index,
    input  logic [bvt_pkg::IN_COUNT_W-1:0] s_bin_count,
    input  logic                           s_last_bin,
    output logic                           m_valid,
    input  logic                           m_ready,
    output logic [bvt_pkg::LEVEL_W-1:0]    m_threshold_level,
    output logic [bvt_pkg::LEVEL_W-1:0]    m_first_peak,
    output logic [bvt_pkg::LEVEL_W-1:0]    m_second_peak
);
    import bvt_pkg::*;

    scan_cmd_t    cmd;
    scan_status_t status;
    logic         wr_accept;

    assign wr_accept = s_valid && s_ready;

    bvt_ctrl u_ctrl (
        .aclk       (aclk),
        .aresetn    (aresetn),
        .s_valid    (s_valid),
        .s_last_bin (s_last_bin),
        .s_ready    (s_ready),
        .m_valid    (m_valid),
        .m_ready    (m_ready),
        .cmd        (cmd),
        .status     (status)
    );

    bvt_datapath u_datapath (
        .aclk            (aclk),
        .aresetn         (aresetn),
        .wr_accept       (wr_accept),
        .s_bin_index     (s_bin_index),
        .s_bin_count     (s_bin_count),
        .cmd             (cmd),
        .status          (status),
        .threshold_level (m_threshold_level),
        .first_peak      (m_first_peak),
        .second_peak     (m_second_peak)
    );

endmodule

@@ hw/rtl/bvt_ram.sv @@
// ----------------------------------------------------------------------------
// bvt_ram: generic single write, single read RAM
// One write port and one read port; read data is registered.
// ----------------------------------------------------------------------------
module bvt_ram #(
    parameter int WIDTH = 24,
    parameter int DEPTH = 256
) (
    input  logic                     aclk,
    input  logic                     wr_en,
    input  logic [$clog2(DEPTH)-1:0] wr_addr,
    input  logic [WIDTH-1:0]         wr_data,
    input  logic [$clog2(DEPTH)-1:0] rd_addr,
    output logic [WIDTH-1:0]         rd_data
);

    logic [WIDTH-1:0] mem_reg [DEPTH];
    logic [WIDTH-1:0] rd_data_reg;

    always_ff @(posedge aclk) begin
        if (wr_en) begin
            mem_reg[wr_addr] <= wr_data;
        end
        rd_data_reg <= mem_reg[rd_addr];
    end

    assign rd_data = rd_data_reg;

endmodule

@@ hw/rtl/bvt_ctrl.sv @@
// ----------------------------------------------------------------------------
// bvt_ctrl: sequencer of the bimodal valley threshold core
// Runs the three scans in turn and handles both handshakes.
// ----------------------------------------------------------------------------
module bvt_ctrl (
    input  logic                  aclk,
    input  logic                  aresetn,
    input  logic                  s_valid,
    input  logic                  s_last_bin,
    output logic                  s_ready,
    output logic                  m_valid,
    input  logic                  m_ready,
    output bvt_pkg::scan_cmd_t    cmd,
    input  bvt_pkg::scan_status_t status
);
    import bvt_pkg::*;

    ctrl_state_t state_reg;
    ctrl_state_t state_next;
    logic        start_search;

    assign start_search = s_valid && s_ready && s_last_bin;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg <= ST_IDLE;
        end else begin
            state_reg <= state_next;
        end
    end

    always_comb begin
        state_next = state_reg;
        unique case (state_reg)
            ST_IDLE: begin
                if (start_search) state_next = ST_START_ONE;
            end
            ST_START_ONE:   state_next = ST_RUN_ONE;
            ST_RUN_ONE: begin
                if (status.scan_done) state_next = ST_START_TWO;
            end
            ST_START_TWO:   state_next = ST_RUN_TWO;
            ST_RUN_TWO: begin
                if (status.scan_done) state_next = ST_START_THREE;
            end
            ST_START_THREE: state_next = ST_RUN_THREE;
            ST_RUN_THREE: begin
                if (status.scan_done) state_next = ST_DONE;
            end
            ST_DONE: begin
                // a new histogram may finish loading while the result waits
                if (start_search) begin
                    state_next = m_ready ? ST_START_ONE : ST_HOLD;
                end else if (m_ready) begin
                    state_next = ST_IDLE;
                end
            end
            ST_HOLD: begin
                if (m_ready) state_next = ST_START_ONE;
            end
            default: state_next = ST_IDLE;
        endcase
    end

    always_comb begin
        s_ready   = 1'b0;
        m_valid   = 1'b0;
        cmd.start = 1'b0;
        cmd.mode  = SCAN_PEAK_ONE;
        unique case (state_reg)
            ST_IDLE:        s_ready = 1'b1;
            ST_START_ONE: begin
                cmd.start = 1'b1;
                cmd.mode  = SCAN_PEAK_ONE;
            end
            ST_RUN_ONE:     cmd.mode = SCAN_PEAK_ONE;
            ST_START_TWO: begin
                cmd.start = 1'b1;
                cmd.mode  = SCAN_PEAK_TWO;
            end
            ST_RUN_TWO:     cmd.mode = SCAN_PEAK_TWO;
            ST_START_THREE: begin
                cmd.start = 1'b1;
                cmd.mode  = SCAN_VALLEY;
            end
            ST_RUN_THREE:   cmd.mode = SCAN_VALLEY;
            ST_DONE: begin
                s_ready = 1'b1;
                m_valid = 1'b1;
            end
            ST_HOLD:        m_valid = 1'b1;
            default: begin
                s_ready = 1'b0;
            end
        endcase
    end

endmodule

@@ hw/rtl/bvt_datapath.sv @@
// ----------------------------------------------------------------------------
// bvt_datapath: bin store and scan pipeline
// Address counter, registered read, key stage and running best compare.
// ----------------------------------------------------------------------------
module bvt_datapath (
    input  logic                              aclk,
    input  logic                              aresetn,
    input  logic                              wr_accept,
    input  logic [7:0]                        s_bin_index,
    input  logic [bvt_pkg::IN_COUNT_W-1:0]    s_bin_count,
    input  bvt_pkg::scan_cmd_t                cmd,
    output bvt_pkg::scan_status_t             status,
    output logic [bvt_pkg::LEVEL_W-1:0]       threshold_level,
    output logic [bvt_pkg::LEVEL_W-1:0]       first_peak,
    output logic [bvt_pkg::LEVEL_W-1:0]       second_peak
);
    import bvt_pkg::*;

    logic                  in_range;
    logic                  ram_wr_en;
    logic [ADDR_BITS-1:0]  ram_wr_addr;
    logic [COUNT_BITS-1:0] ram_wr_data;
    logic [COUNT_BITS-1:0] ram_rd_data;

    scan_mode_t            mode_reg;
    logic [ADDR_BITS-1:0]  addr_reg;
    logic [ADDR_BITS-1:0]  end_reg;
    logic                  issuing_reg;

    logic                  rd_valid_reg;
    logic                  rd_last_reg;
    logic [ADDR_BITS-1:0]  rd_idx_reg;
    logic [ADDR_BITS-1:0]  rd_dist_reg;
    logic [ADDR_BITS-1:0]  dist_next;

    logic                  key_valid_reg;
    logic                  key_last_reg;
    logic [ADDR_BITS-1:0]  key_idx_reg;
    logic [PROD_BITS-1:0]  key_reg;
    logic [PROD_BITS-1:0]  key_next;

    logic                  first_reg;
    logic [PROD_BITS-1:0]  best_product_reg;
    logic                  better;
    logic                  done_reg;

    logic [ADDR_BITS-1:0]  peak_one_reg;
    logic [ADDR_BITS-1:0]  peak_two_reg;
    logic [ADDR_BITS-1:0]  thresh_reg;

    logic [ADDR_BITS-1:0]  lo_peak;
    logic [ADDR_BITS-1:0]  hi_peak;
    logic [ADDR_BITS-1:0]  start_addr;
    logic [ADDR_BITS-1:0]  end_addr;

    // bin store write side
    assign in_range    = 32'(s_bin_index) < 32'(BINS);
    assign ram_wr_en   = wr_accept && in_range;
    assign ram_wr_addr = ADDR_BITS'(s_bin_index);
    assign ram_wr_data = sat_count(s_bin_count);

    bvt_ram #(
        .WIDTH (COUNT_BITS),
        .DEPTH (BINS)
    ) u_bin_store (
        .aclk    (aclk),
        .wr_en   (ram_wr_en),
        .wr_addr (ram_wr_addr),
        .wr_data (ram_wr_data),
        .rd_addr (addr_reg),
        .rd_data (ram_rd_data)
    );

    // scan range: valley scan covers lower peak up to one below the upper peak
    assign lo_peak = (peak_one_reg < peak_two_reg) ? peak_one_reg : peak_two_reg;
    assign hi_peak = (peak_one_reg < peak_two_reg) ? peak_two_reg : peak_one_reg;

    always_comb begin
        case (cmd.mode)
            SCAN_VALLEY: begin
                start_addr = lo_peak;
                end_addr   = (hi_peak > lo_peak) ? hi_peak - ADDR_BITS'(1) : lo_peak;
            end
            default: begin
                start_addr = '0;
                end_addr   = ADDR_BITS'(BINS - 1);
            end
        endcase
    end

    assign dist_next = (addr_reg > peak_one_reg) ? addr_reg - peak_one_reg
                                                 : peak_one_reg - addr_reg;

    always_comb begin
        case (mode_reg)
            SCAN_PEAK_TWO: key_next = PROD_BITS'(ram_rd_data) * PROD_BITS'(rd_dist_reg);
            default:       key_next = PROD_BITS'(ram_rd_data);
        endcase
    end

    always_comb begin
        case (mode_reg)
            SCAN_VALLEY: better = key_reg < best_product_reg;
            default:     better = key_reg > best_product_reg;
        endcase
    end

    // address issue
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            issuing_reg <= 1'b0;
            mode_reg    <= SCAN_PEAK_ONE;
            addr_reg    <= '0;
            end_reg     <= '0;
        end else if (cmd.start) begin
            issuing_reg <= 1'b1;
            mode_reg    <= cmd.mode;
            addr_reg    <= start_addr;
            end_reg     <= end_addr;
        end else if (issuing_reg) begin
            if (addr_reg == end_reg) begin
                issuing_reg <= 1'b0;
            end else begin
                addr_reg <= addr_reg + ADDR_BITS'(1);
            end
        end
    end

    // read and key stages
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            rd_valid_reg  <= 1'b0;
            key_valid_reg <= 1'b0;
        end else begin
            rd_valid_reg  <= issuing_reg && !cmd.start;
            key_valid_reg <= rd_valid_reg;
        end
    end

    always_ff @(posedge aclk) begin
        rd_last_reg  <= addr_reg == end_reg;
        rd_idx_reg   <= addr_reg;
        rd_dist_reg  <= dist_next;
        key_last_reg <= rd_last_reg;
        key_idx_reg  <= rd_idx_reg;
        key_reg      <= key_next;
    end

    // running best, first element of a scan taken as is
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            first_reg        <= 1'b0;
            done_reg         <= 1'b0;
            best_product_reg <= '0;
            peak_one_reg     <= '0;
            peak_two_reg     <= '0;
            thresh_reg       <= '0;
        end else begin
            done_reg <= !cmd.start && key_valid_reg && key_last_reg;
            if (cmd.start) begin
                first_reg <= 1'b1;
            end else if (key_valid_reg) begin
                first_reg <= 1'b0;
                if (first_reg || better) begin
                    best_product_reg <= key_reg;
                    case (mode_reg)
                        SCAN_PEAK_ONE: peak_one_reg <= key_idx_reg;
                        SCAN_PEAK_TWO: peak_two_reg <= key_idx_reg;
                        default:       thresh_reg   <= key_idx_reg;
                    endcase
                end
            end
        end
    end

    assign status.scan_done = done_reg;
    assign threshold_level  = LEVEL_W'(thresh_reg);
    assign first_peak       = LEVEL_W'(peak_one_reg);
    assign second_peak      = LEVEL_W'(peak_two_reg);

endmodule
